[sv/deq_pkg.sv]
// Types and constants shared by the double-ended queue modules.
`default_nettype none

package deq_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned FILL_W = 5;
  localparam int unsigned KIND_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_DUMP       = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [WORD_W-1:0] value;
  } deq_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    logic                     last;
    logic [FILL_W-1:0]        fill;
    logic [1:0]               status;
  } deq_out_t;

  typedef struct packed {
    logic    push_front;
    logic    push_back;
    logic    pop_front;
    logic    pop_back;
    logic    load_status;
    status_e status;
    logic    dump_clear;
    logic    dump_read;
    logic    dump_emit;
  } deq_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic out_free;
    logic dump_last;
  } deq_stat_t;

endpackage

`default_nettype wire

[sv/deq_ctrl.sv]
// Controller state machine for the double-ended queue.
`default_nettype none

module deq_ctrl (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire logic [deq_pkg::KIND_W-1:0] kind_i,
  output logic                          in_ready_o,
  input  wire deq_pkg::deq_stat_t       stat_i,
  output deq_pkg::deq_cmd_t             cmd_o
);
  import deq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DUMP_RD,
    S_DUMP_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE) && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    cmd_o.status = ST_OK;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (kind_i)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
              cmd_o.load_status = 1'b1;
              if (stat_i.full) begin
                cmd_o.status = ST_FULL;
              end else begin
                cmd_o.push_front = (kind_i == KIND_PUSH_FRONT);
                cmd_o.push_back  = (kind_i == KIND_PUSH_BACK);
              end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
              cmd_o.load_status = 1'b1;
              if (stat_i.empty) begin
                cmd_o.status = ST_EMPTY;
              end else begin
                cmd_o.pop_front = (kind_i == KIND_POP_FRONT);
                cmd_o.pop_back  = (kind_i == KIND_POP_BACK);
              end
            end
            KIND_DUMP: begin
              if (stat_i.empty) begin
                cmd_o.load_status = 1'b1;
                cmd_o.status      = ST_EMPTY;
              end else begin
                cmd_o.dump_clear = 1'b1;
                state_d          = S_DUMP_RD;
              end
            end
            default: begin
              cmd_o.load_status = 1'b1;
            end
          endcase
        end
      end
      S_DUMP_RD: begin
        cmd_o.dump_read = 1'b1;
        state_d         = S_DUMP_EMIT;
      end
      S_DUMP_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.dump_emit = 1'b1;
          state_d         = stat_i.dump_last ? S_IDLE : S_DUMP_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[sv/deq_dpath.sv]
// Datapath for the double-ended queue: ring store, pointers, count, result register.
`default_nettype none

module deq_dpath #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic signed [deq_pkg::WORD_W-1:0] value_i,
  input  wire deq_pkg::deq_cmd_t           cmd_i,
  output deq_pkg::deq_stat_t               stat_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output deq_pkg::deq_out_t                out_data_o
);
  import deq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_A) begin
      s = s - DEPTH_A;
    end
    return s[AW-1:0];
  endfunction

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rd_data_q;
  logic [AW-1:0]     front_q, front_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q;
  logic [CW-1:0]     idx_inc;
  logic [AW-1:0]     front_dec;
  logic [AW-1:0]     back_addr;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic              out_valid_q;
  deq_out_t          out_q;
  logic              out_free;
  logic              out_load;
  logic [CW+FILL_W-1:0] fill_ext;

  assign front_dec = (front_q == '0) ? LAST_A : front_q - AW'(1);
  assign back_addr = wrap_add(front_q, count_q[AW-1:0]);
  assign rd_addr   = wrap_add(front_q, idx_q[AW-1:0]);
  assign idx_inc   = idx_q + CW'(1);

  assign mem_we    = cmd_i.push_front || cmd_i.push_back;
  assign mem_waddr = cmd_i.push_front ? front_dec : back_addr;

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    if (cmd_i.push_front) begin
      front_d = front_dec;
      count_d = count_q + CW'(1);
    end
    if (cmd_i.push_back) begin
      count_d = count_q + CW'(1);
    end
    if (cmd_i.pop_front) begin
      front_d = (front_q == LAST_A) ? '0 : front_q + AW'(1);
      count_d = count_q - CW'(1);
    end
    if (cmd_i.pop_back) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= value_i;
    end
    if (cmd_i.dump_read) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.dump_clear) begin
      idx_q <= '0;
    end else if (cmd_i.dump_emit) begin
      idx_q <= idx_inc;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = cmd_i.load_status || cmd_i.dump_emit;
  assign fill_ext = {{FILL_W{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_status) begin
      out_q.word   <= '0;
      out_q.last   <= 1'b1;
      out_q.fill   <= fill_ext[FILL_W-1:0];
      out_q.status <= cmd_i.status;
    end else if (cmd_i.dump_emit) begin
      out_q.word   <= rd_data_q;
      out_q.last   <= (idx_inc == count_q);
      out_q.fill   <= fill_ext[FILL_W-1:0];
      out_q.status <= ST_OK;
    end
  end

  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q == DEPTH_C);
  assign stat_o.out_free  = out_free;
  assign stat_o.dump_last = (idx_inc == count_q);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[sv/double_ended_queue.sv]
// Top level of the bounded double-ended queue of signed words.
//
//   channel | signals                          | beat
//   --------+----------------------------------+------------------------------
//   in      | in_valid_i, in_ready_o, in_data_i  | kind and value of one operation
//   out     | out_valid_o, out_ready_i, out_data_o | word, last, fill, status
//
// Push, pop and unknown kinds each give one status beat.
// A dump of N held words is accepted first; then for each word the registered
// ring store read is followed by a load of the result register.
// No input beat is taken until the last beat of a dump is loaded.
// The result register frees a slot while the consumer takes it, so stalls on
// out only hold the controller. Reset empties the queue at once.
`default_nettype none

module double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire deq_pkg::deq_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output deq_pkg::deq_out_t      out_data_o
);
  import deq_pkg::*;

  deq_cmd_t  cmd;
  deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (in_data_i.kind),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  deq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (in_data_i.value),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
